// ===== rtl/core/max_priority_queue_core_assert.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("priority queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("priority queue assertion failed");

`endif

// ===== rtl/core/mpq_pkg.sv =====
// Shared types and constants of the priority queue.
package mpq_pkg;

	localparam int VAL_W  = 16;
	localparam int PRIO_W = 8;
	localparam int LIM_W  = 5;
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	localparam logic             REG_LIMIT   = 1'b0;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

	typedef struct packed {
		logic [VAL_W-1:0]  val;
		logic [PRIO_W-1:0] prio;
	} entry_t;

endpackage

// ===== rtl/core/max_priority_queue_core.sv =====
// Top level of the bounded priority queue with extract of the highest priority entry.
//
//  channel   handshake                      payload
//  command   start, busy                    cmd, item_value, item_priority
//  result    done (one-cycle strobe)        extracted_value, found, accepted,
//                                           entry_count, is_empty, is_full
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Add, clear, the unused command and an extract on an empty queue finish when accepted;
// the result strobes in the next cycle.
// An extract of a queue holding n entries scans them through the one memory read port
// with a single priority comparator, then closes the gap with the same port; busy stays
// high through the scan and the shift, and the result strobes in the first cycle with busy low.
// Reset clears the count and sets the limit to 16; the entry memory needs no clearing.
// The result receiver cannot stall; done is high for one cycle only, payload holds till the next.
`include "max_priority_queue_core_assert.svh"

module max_priority_queue_core import mpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [VAL_W-1:0]  item_value,
	input  logic [PRIO_W-1:0] item_priority,
	output logic              done,
	output logic [VAL_W-1:0]  extracted_value,
	output logic              found,
	output logic              accepted,
	output logic [LIM_W-1:0]  entry_count,
	output logic              is_empty,
	output logic              is_full,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int MW = (CW > LIM_W) ? CW : LIM_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [LIM_W-1:0]  limit_q;
	logic [CW-1:0]     idx_q, idx_d;
	logic              pend_q;
	logic [CW-1:0]     pend_idx_q;
	logic [CW-1:0]     best_idx_q, best_idx_d;
	logic [PRIO_W-1:0] best_pri_q, best_pri_d;
	logic [VAL_W-1:0]  best_val_q, best_val_d;

	logic              done_q, done_d;
	logic [VAL_W-1:0]  ext_q, ext_d;
	logic              found_q, found_d;
	logic              acc_q, acc_d;
	logic [LIM_W-1:0]  cnt_res_q;
	logic              empty_q;
	logic              full_res_q;

	logic              accept;
	logic              full_now;
	logic              full_d;
	logic [MW-1:0]     cnt_ext;
	logic              scan_issue;
	logic              shift_issue;
	logic              cmp_take;
	logic              scan_end;
	logic              shift_end;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CW-1:0]     shift_dst;
	entry_t            wdata;
	entry_t            rdata;
	logic              cfg_wr;

	mpq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full_now = (MW'(count_q) >= MW'(limit_q)) || (count_q >= CW'(DEPTH));
	assign full_d   = (MW'(count_d) >= MW'(limit_q)) || (count_d >= CW'(DEPTH));
	assign cnt_ext  = MW'(count_d);

	assign scan_issue  = (state_q == ST_SCAN) && (idx_q < count_q);
	assign shift_issue = (state_q == ST_SHIFT) && (idx_q < count_q);
	assign cmp_take    = (state_q == ST_SCAN) && pend_q
	                     && ((pend_idx_q == '0) || (rdata.prio > best_pri_q));
	assign scan_end    = (state_q == ST_SCAN) && !scan_issue && !pend_q;
	assign shift_end   = (state_q == ST_SHIFT) && !shift_issue && !pend_q;
	assign shift_dst   = pend_idx_q - CW'(1);

	always_comb begin
		if (state_q == ST_SHIFT) begin
			we    = pend_q;
			waddr = shift_dst[AW-1:0];
			wdata = rdata;
		end else begin
			we         = accept && (cmd == CMD_ADD) && !full_now;
			waddr      = count_q[AW-1:0];
			wdata.val  = item_value;
			wdata.prio = item_priority;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		best_idx_d = best_idx_q;
		best_pri_d = best_pri_q;
		best_val_d = best_val_q;
		done_d     = 1'b0;
		ext_d      = '0;
		found_d    = 1'b0;
		acc_d      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_ADD: begin
							done_d = 1'b1;
							if (!full_now) begin
								count_d = count_q + CW'(1);
								acc_d   = 1'b1;
							end
						end
						CMD_EXTRACT: begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								state_d = ST_SCAN;
								idx_d   = '0;
							end
						end
						CMD_CLEAR: begin
							done_d  = 1'b1;
							count_d = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (cmp_take) begin
					best_idx_d = pend_idx_q;
					best_pri_d = rdata.prio;
					best_val_d = rdata.val;
				end
				if (scan_end) begin
					state_d = ST_SHIFT;
					idx_d   = best_idx_q + CW'(1);
				end
			end
			ST_SHIFT: begin
				if (shift_issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (shift_end) begin
					state_d = ST_IDLE;
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					found_d = 1'b1;
					ext_d   = best_val_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= scan_issue || shift_issue;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		pend_idx_q <= idx_q;
		best_idx_q <= best_idx_d;
		best_pri_q <= best_pri_d;
		best_val_q <= best_val_d;
		if (done_d) begin
			ext_q      <= ext_d;
			found_q    <= found_d;
			acc_q      <= acc_d;
			cnt_res_q  <= cnt_ext[LIM_W-1:0];
			empty_q    <= (count_d == '0);
			full_res_q <= full_d;
		end
	end

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_LIMIT)) begin
			limit_q <= pwdata[LIM_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_q) : '0;

	assign done            = done_q;
	assign extracted_value = ext_q;
	assign found           = found_q;
	assign accepted        = acc_q;
	assign entry_count     = cnt_res_q;
	assign is_empty        = empty_q;
	assign is_full         = full_res_q;

	`MPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`MPQ_ASSERT_SAME(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`MPQ_ASSERT_SAME(a_found_not_acc, clk, arst_n, done_q, !(found_q && acc_q))
	`MPQ_ASSERT_NEXT(a_add_grows, clk, arst_n, accept && (cmd == CMD_ADD) && !full_now,
		count_q == $past(count_q) + CW'(1))

endmodule

// ===== rtl/core/mpq_store.sv =====
// Entry memory of the priority queue: one write port and one registered read port.
module mpq_store import mpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
